// ===== rtl/core/wsd_pkg.sv =====
// Shared types and codes for the frame deframer.
// Holds opcodes, status codes and the command word passed from parser to emitter.
// No dependencies.
package wsd_pkg;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [1:0] ST_TEXT_OK = 2'd0;
	localparam logic [1:0] ST_CLOSING = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic       has_pay;
		logic [7:0] pay;
		logic       has_stat;
		logic [1:0] stat;
	} cmd_t;

endpackage

// ===== rtl/core/wsd_front.sv =====
// Header parser and unmasker: takes one frame byte per transaction.
// Produces a command word per byte that causes results.
// Depends on wsd_pkg.
module wsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              frame_end,
	output logic              cmd_valid,
	output wsd_pkg::cmd_t     cmd
);

	localparam logic [2:0] POS_B0      = 3'd0;
	localparam logic [2:0] POS_B1      = 3'd1;
	localparam logic [2:0] POS_EXT_HI  = 3'd2;
	localparam logic [2:0] POS_EXT_LO  = 3'd3;
	localparam logic [2:0] POS_MASK    = 3'd4;
	localparam logic [2:0] POS_PAYLOAD = 3'd5;
	localparam logic [2:0] POS_DONE    = 3'd6;

	logic [2:0]  pos_q, pos_n;
	logic [3:0]  op_q, op_n;
	logic        bad_q, bad_n;
	logic [15:0] len_q, len_n;
	logic [31:0] key_q, key_n;
	logic [15:0] idx_q, idx_n;
	logic [15:0] idx_inc;
	logic        op_known;
	logic [7:0]  key_byte;
	logic        has_pay;
	logic [7:0]  pay;
	logic [1:0]  stat;

	assign idx_inc = idx_q + 16'd1;

	always_comb begin
		unique case (in_byte[3:0])
			wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY, wsd_pkg::OP_PING, wsd_pkg::OP_PONG:
				op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	end

	always_comb begin
		unique case (idx_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		pos_n   = pos_q;
		op_n    = op_q;
		bad_n   = bad_q;
		len_n   = len_q;
		key_n   = key_q;
		idx_n   = idx_q;
		has_pay = 1'b0;
		pay     = 8'd0;
		unique case (pos_q)
			POS_B0: begin
				op_n  = in_byte[3:0];
				bad_n = bad_q | (in_byte[6:4] != 3'd0) | ~in_byte[7];
				if (in_byte[3:0] == wsd_pkg::OP_CLOSE) begin
					pos_n = POS_DONE;
				end else if (!op_known) begin
					bad_n = 1'b1;
					pos_n = POS_DONE;
				end else if (bad_n) begin
					pos_n = POS_DONE;
				end else begin
					pos_n = POS_B1;
				end
			end
			POS_B1: begin
				bad_n = bad_q | ~in_byte[7];
				if (op_q != wsd_pkg::OP_TEXT || bad_n) begin
					pos_n = POS_DONE;
				end else if (in_byte[6:0] == 7'h7F) begin
					bad_n = 1'b1;
					pos_n = POS_DONE;
				end else if (in_byte[6:0] == 7'h7E) begin
					pos_n = POS_EXT_HI;
				end else begin
					len_n = {9'd0, in_byte[6:0]};
					idx_n = 16'd0;
					pos_n = (in_byte[6:0] == 7'd0) ? POS_DONE : POS_MASK;
				end
			end
			POS_EXT_HI: begin
				len_n = {in_byte, 8'd0};
				pos_n = POS_EXT_LO;
			end
			POS_EXT_LO: begin
				len_n = {len_q[15:8], in_byte};
				idx_n = 16'd0;
				pos_n = (len_n == 16'd0) ? POS_DONE : POS_MASK;
			end
			POS_MASK: begin
				key_n = {key_q[23:0], in_byte};
				if (idx_inc >= 16'd4) begin
					idx_n = 16'd0;
					pos_n = POS_PAYLOAD;
				end else begin
					idx_n = idx_inc;
				end
			end
			POS_PAYLOAD: begin
				has_pay = 1'b1;
				pay     = in_byte ^ key_byte;
				idx_n   = idx_inc;
				if (idx_inc == len_q) begin
					pos_n = POS_DONE;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (op_n == wsd_pkg::OP_CLOSE) begin
			stat = wsd_pkg::ST_CLOSING;
		end else if (bad_n || pos_n != POS_DONE) begin
			stat = wsd_pkg::ST_ERROR;
		end else if (op_n == wsd_pkg::OP_TEXT) begin
			stat = wsd_pkg::ST_TEXT_OK;
		end else begin
			stat = wsd_pkg::ST_IGNORED;
		end
	end

	assign cmd_valid    = accept & (has_pay | frame_end);
	assign cmd.has_pay  = has_pay;
	assign cmd.pay      = pay;
	assign cmd.has_stat = frame_end;
	assign cmd.stat     = stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_B0;
			op_q  <= 4'd0;
			bad_q <= 1'b0;
			len_q <= 16'd0;
			key_q <= 32'd0;
			idx_q <= 16'd0;
		end else if (accept) begin
			if (frame_end) begin
				pos_q <= POS_B0;
				op_q  <= 4'd0;
				bad_q <= 1'b0;
				len_q <= 16'd0;
				key_q <= 32'd0;
				idx_q <= 16'd0;
			end else begin
				pos_q <= pos_n;
				op_q  <= op_n;
				bad_q <= bad_n;
				len_q <= len_n;
				key_q <= key_n;
				idx_q <= idx_n;
			end
		end
	end

endmodule

// ===== rtl/core/wsd_queue.sv =====
// Short command queue between parser and emitter.
// Depends on wsd_pkg for the command type and depth.
module wsd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  wsd_pkg::cmd_t wr_cmd,
	input  logic          rd,
	output wsd_pkg::cmd_t rd_cmd,
	output logic          q_full,
	output logic          q_empty
);

	wsd_pkg::cmd_t             mem_q [wsd_pkg::QDEPTH];
	logic [wsd_pkg::QAW-1:0]   wp_q, rp_q;
	logic [wsd_pkg::QAW:0]     cnt_q;

	assign q_full  = (cnt_q == (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_cmd  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/wsd_back.sv =====
// Result emitter: holds one command, shows payload byte then status, or just one.
// Depends on wsd_pkg.
module wsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  wsd_pkg::cmd_t q_cmd,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output logic          kind,
	output logic [7:0]    payload_byte,
	output logic [1:0]    frame_status,
	output logic          last
);

	logic          valid_q;
	logic          stat_phase_q;
	wsd_pkg::cmd_t cur_q;
	logic          show_stat;
	logic          take;
	logic          finish;

	assign show_stat = stat_phase_q | ~cur_q.has_pay;
	assign take      = valid_q & pop;
	assign finish    = take & (show_stat | ~cur_q.has_stat);
	assign q_rd      = ~q_empty & (~valid_q | finish);

	assign empty        = ~valid_q;
	assign kind         = show_stat;
	assign payload_byte = show_stat ? 8'd0 : cur_q.pay;
	assign frame_status = show_stat ? cur_q.stat : 2'd0;
	assign last         = show_stat;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			stat_phase_q <= 1'b0;
		end else begin
			if (q_rd) begin
				valid_q      <= 1'b1;
				stat_phase_q <= 1'b0;
			end else if (finish) begin
				valid_q      <= 1'b0;
				stat_phase_q <= 1'b0;
			end else if (take) begin
				stat_phase_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the frame deframer: parser, command queue, result emitter.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
//
//   channel   handshake      payload
//   input     push / full    in_byte, frame_end
//   result    pop / empty    kind, payload_byte, frame_status, last
//
// One byte is taken each cycle while the four-entry command queue has room.
// A payload byte that also ends its frame gives two results, emitted on two pops.
// A byte's result is queued, then held in the emitter; full rises only when the queue fills.
// Reset clears parser state, queue pointers and the emitter's valid flag.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       frame_end,
	output logic       empty,
	input  logic       pop,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic [1:0] frame_status,
	output logic       last
);

	logic          accept;
	logic          cmd_valid;
	wsd_pkg::cmd_t cmd;
	wsd_pkg::cmd_t q_cmd;
	logic          q_rd;
	logic          q_empty;

	assign accept = push & ~full;

	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.frame_end (frame_end),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	wsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_valid),
		.wr_cmd  (cmd),
		.rd      (q_rd),
		.rd_cmd  (q_cmd),
		.q_full  (full),
		.q_empty (q_empty)
	);

	wsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_cmd),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.payload_byte (payload_byte),
		.frame_status (frame_status),
		.last         (last)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer: random and directed frames, XOR unmasking
// and end-of-frame status predicted in-bench, compared per field against the DUT result queue.
// Depends on wsd_pkg and the deframer RTL.
module tb_top;

	localparam logic [2:0] POS_B0      = 3'd0;
	localparam logic [2:0] POS_B1      = 3'd1;
	localparam logic [2:0] POS_EXT_HI  = 3'd2;
	localparam logic [2:0] POS_EXT_LO  = 3'd3;
	localparam logic [2:0] POS_MASK    = 3'd4;
	localparam logic [2:0] POS_PAYLOAD = 3'd5;
	localparam logic [2:0] POS_DONE    = 3'd6;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam int STALL_LIMIT = 2000;
	localparam int TARGET_BYTES = 1200;

	typedef struct packed {
		logic       kind;
		logic [7:0] pay;
		logic [1:0] stat;
		logic       last;
	} frame_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       drain;
	} wire_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       frame_end = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic       kind;
	logic [7:0] payload_byte;
	logic [1:0] frame_status;
	logic       last;

	wire_byte_t    wire_bytes[$];
	logic [7:0]    frame_buf[$];
	frame_result_t predicted_results[$];

	logic [2:0]  hdr_pos;
	logic [3:0]  opcode;
	logic        hdr_bad;
	logic        ext_used;
	logic [15:0] pay_len;
	logic [31:0] mask_word;
	logic [15:0] pay_idx;

	int total_bytes = 0;
	int bytes_taken = 0;
	int errors = 0;
	int stalled = 0;

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.frame_end(frame_end),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.payload_byte(payload_byte),
		.frame_status(frame_status),
		.last(last)
	);

	always #5 clk = ~clk;

	function automatic void clear_frame();
		hdr_pos = POS_B0;
		opcode = 4'h0;
		hdr_bad = 1'b0;
		ext_used = 1'b0;
		pay_len = 16'h0;
		mask_word = 32'h0;
		pay_idx = 16'h0;
	endfunction

	function automatic void enter_mask();
		pay_idx = 16'h0;
		hdr_pos = (pay_len == 16'h0) ? POS_DONE : POS_MASK;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic fin);
		frame_result_t r;
		logic [7:0] key_byte;
		case (hdr_pos)
			POS_B0: begin
				opcode = b[3:0];
				if (b[6:4] != 3'b000 || !b[7])
					hdr_bad = 1'b1;
				if (opcode == wsd_pkg::OP_CLOSE) begin
					hdr_pos = POS_DONE;
				end else if (opcode != wsd_pkg::OP_TEXT && opcode != wsd_pkg::OP_BINARY &&
						opcode != wsd_pkg::OP_PING && opcode != wsd_pkg::OP_PONG) begin
					hdr_bad = 1'b1;
					hdr_pos = POS_DONE;
				end else if (hdr_bad) begin
					hdr_pos = POS_DONE;
				end else begin
					hdr_pos = POS_B1;
				end
			end
			POS_B1: begin
				if (!b[7])
					hdr_bad = 1'b1;
				if (opcode != wsd_pkg::OP_TEXT || hdr_bad) begin
					hdr_pos = POS_DONE;
				end else if (b[6:0] == 7'h7F) begin
					hdr_bad = 1'b1;
					hdr_pos = POS_DONE;
				end else if (b[6:0] == 7'h7E) begin
					ext_used = 1'b1;
					hdr_pos = POS_EXT_HI;
				end else begin
					pay_len = {9'h0, b[6:0]};
					enter_mask();
				end
			end
			POS_EXT_HI: begin
				pay_len = {b, 8'h00};
				hdr_pos = POS_EXT_LO;
			end
			POS_EXT_LO: begin
				pay_len = pay_len | {8'h00, b};
				enter_mask();
			end
			POS_MASK: begin
				mask_word = {mask_word[23:0], b};
				pay_idx = pay_idx + 16'd1;
				if (pay_idx >= 16'd4) begin
					pay_idx = 16'h0;
					hdr_pos = POS_PAYLOAD;
				end
			end
			POS_PAYLOAD: begin
				key_byte = 8'(mask_word >> (8 * (3 - pay_idx[1:0])));
				r.kind = KIND_PAYLOAD;
				r.pay = b ^ key_byte;
				r.stat = 2'd0;
				r.last = 1'b0;
				predicted_results.push_back(r);
				pay_idx = pay_idx + 16'd1;
				if (pay_idx == pay_len)
					hdr_pos = POS_DONE;
			end
			default: begin
			end
		endcase
		if (fin) begin
			r.kind = KIND_STATUS;
			r.pay = 8'h00;
			r.last = 1'b1;
			if (opcode == wsd_pkg::OP_CLOSE)
				r.stat = wsd_pkg::ST_CLOSING;
			else if (hdr_bad || hdr_pos != POS_DONE)
				r.stat = wsd_pkg::ST_ERROR;
			else if (opcode == wsd_pkg::OP_TEXT)
				r.stat = wsd_pkg::ST_TEXT_OK;
			else
				r.stat = wsd_pkg::ST_IGNORED;
			predicted_results.push_back(r);
			clear_frame();
		end
	endfunction

	function automatic int idle_pct(input bit receiver);
		if (bytes_taken < total_bytes / 3)
			return receiver ? 69 : 12;
		if (bytes_taken < 2 * total_bytes / 3)
			return receiver ? 12 : 69;
		return 0;
	endfunction

	task automatic put(input logic [7:0] b);
		frame_buf.push_back(b);
	endtask

	task automatic ship(input bit drain);
		wire_byte_t w;
		for (int i = 0; i < frame_buf.size(); i++) begin
			w.data = frame_buf[i];
			w.fin = (i == frame_buf.size() - 1);
			w.drain = drain && (i == 0);
			wire_bytes.push_back(w);
		end
		frame_buf.delete();
	endtask

	task automatic text_frame(input int len, input bit ext, input bit trunc, input int extra);
		logic [15:0] l16;
		int n;
		int keep;
		l16 = 16'(len);
		n = len;
		put({1'b1, 3'b000, wsd_pkg::OP_TEXT});
		if (ext) begin
			put(8'hFE);
			put(l16[15:8]);
			put(l16[7:0]);
		end else begin
			put({1'b1, l16[6:0]});
		end
		if (len > 200) begin
			trunc = 1'b1;
			n = $urandom_range(0, 30);
		end
		if (len != 0 || $urandom_range(0, 1) == 1)
			repeat (4) put(8'($urandom_range(0, 255)));
		repeat (n) put(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
		if (trunc && frame_buf.size() > 1) begin
			keep = $urandom_range(1, frame_buf.size() - 1);
			while (frame_buf.size() > keep)
				void'(frame_buf.pop_back());
		end
		repeat (extra) put(8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic go;
		if (!arst_n) begin
			push <= 1'b0;
			in_byte <= 8'h00;
			frame_end <= 1'b0;
		end else begin
			go = push;
			if (push && !full) begin
				deframe_byte(in_byte, frame_end);
				void'(wire_bytes.pop_front());
				bytes_taken++;
				go = 1'b0;
			end
			if (!go && wire_bytes.size() != 0 &&
					!(wire_bytes[0].drain && predicted_results.size() != 0) &&
					$urandom_range(0, 99) >= idle_pct(1'b0))
				go = 1'b1;
			push <= go;
			if (go) begin
				in_byte <= wire_bytes[0].data;
				frame_end <= wire_bytes[0].fin;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (predicted_results.size() == 0) begin
					$error("unexpected result: kind %0d byte %0h status %0d last %0d",
						kind, payload_byte, frame_status, last);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						errors++;
					end
					if (payload_byte !== want.pay) begin
						$error("payload_byte: expected %0h, actual %0h", want.pay, payload_byte);
						errors++;
					end
					if (frame_status !== want.stat) begin
						$error("frame_status: expected %0d, actual %0d", want.stat, frame_status);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stalled = 0;
		else
			stalled++;
		if (stalled >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int sel;
		int len;
		bit ext;
		bit drain_marked;
		logic [3:0] op;
		clear_frame();
		drain_marked = 1'b0;

		put({1'b1, 3'b000, wsd_pkg::OP_CLOSE}); ship(1'b0);
		put({1'b0, 3'b111, wsd_pkg::OP_CLOSE}); put(8'hFF); ship(1'b0);
		text_frame(2, 1'b0, 1'b0, 0); ship(1'b0);
		put({1'b1, 3'b111, wsd_pkg::OP_TEXT}); ship(1'b0);
		put({1'b0, 3'b000, wsd_pkg::OP_TEXT}); ship(1'b0);
		put(8'h80); ship(1'b0);
		put(8'h8F); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_BINARY}); put(8'hFF); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_PING}); put(8'h80); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_PONG}); put(8'h00); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_PONG}); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_TEXT}); put(8'h05); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_TEXT}); put(8'hFF); ship(1'b0);
		put({1'b1, 3'b000, wsd_pkg::OP_TEXT}); put(8'h80); ship(1'b0);
		text_frame(1, 1'b1, 1'b0, 1); ship(1'b0);
		text_frame(0, 1'b1, 1'b0, 0); ship(1'b0);
		text_frame(125, 1'b0, 1'b1, 0); ship(1'b0);
		text_frame(65535, 1'b1, 1'b1, 0); ship(1'b1);

		while (wire_bytes.size() < TARGET_BYTES) begin
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				ext = ($urandom_range(0, 4) == 0);
				if (ext)
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 40);
				else
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125)
						: $urandom_range(0, 12);
				text_frame(len, ext, $urandom_range(0, 9) == 0,
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			end else if (sel < 75) begin
				case ($urandom_range(0, 3))
					0: op = wsd_pkg::OP_BINARY;
					1: op = wsd_pkg::OP_PING;
					2: op = wsd_pkg::OP_PONG;
					default: op = wsd_pkg::OP_CLOSE;
				endcase
				put({1'b1, ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'b000, op});
				repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
			end else if (sel < 88) begin
				put(8'($urandom_range(0, 255)) ^ {4'h8, wsd_pkg::OP_TEXT});
				put(8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
			end
			ship(!drain_marked && wire_bytes.size() > TARGET_BYTES / 2);
			if (wire_bytes.size() > TARGET_BYTES / 2)
				drain_marked = 1'b1;
		end
		total_bytes = wire_bytes.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (wire_bytes.size() != 0 || push || predicted_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
